/* rtl/uvg_pkg.sv */
package uvg_pkg;

  // Divide by 1000 is done as a long division over 16-bit chunks of the
  // microsecond time. Each chunk step forms a 26-bit partial value, whose
  // quotient is found exactly by a 27-bit reciprocal and a shift.
  localparam int unsigned TIME_W      = 64;
  localparam int unsigned CHUNK_W     = 16;
  localparam int unsigned N_CHUNKS    = TIME_W / CHUNK_W;
  localparam int unsigned REM_W       = 10;
  localparam int unsigned V_W         = REM_W + CHUNK_W;
  localparam int unsigned RECIP_W     = 27;
  localparam int unsigned PROD_W      = V_W + RECIP_W;
  localparam int unsigned RECIP_SHIFT = 36;

  localparam logic [REM_W-1:0]   US_PER_MS = 10'd1000;
  // ceil(2^36 / 1000); the error term keeps the quotient exact for any
  // partial value below 1000 * 2^16.
  localparam logic [RECIP_W-1:0] RECIP_M   = 27'd68719477;

  localparam int unsigned TOP_W = 12;
  localparam int unsigned MID_W = 14;
  localparam int unsigned LOW_W = 48;
  localparam int unsigned CNT_W = TOP_W + MID_W + LOW_W;

  localparam logic [3:0] VERSION = 4'h7;
  localparam logic [1:0] VARIANT = 2'b10;

  typedef struct packed {
    logic [TIME_W-1:0] ms;
    logic [REM_W-1:0]  sub;
    logic [TOP_W-1:0]  seed_high;
    logic [MID_W-1:0]  seed_mid;
    logic [LOW_W-1:0]  seed_low;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } item_beat_t;

  typedef struct packed {
    logic [63:0] upper;
    logic [63:0] lower;
  } result_t;

endpackage

/* rtl/uvg_fifo.sv */
module uvg_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             wr;
  logic             rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign wr      = push && !full;
  assign rd      = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/uvg_front.sv */
module uvg_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [63:0]            time_us,
  input  logic [11:0]            seed_high,
  input  logic [13:0]            seed_mid,
  input  logic [47:0]            seed_low,
  output logic                   full,
  input  logic                   out_ready,
  output uvg_pkg::item_beat_t    out
);

  localparam int unsigned NC = uvg_pkg::N_CHUNKS;

  // Beat after the reciprocal multiply of one chunk step.
  typedef struct packed {
    logic                           valid;
    logic [uvg_pkg::TIME_W-1:0]     t;
    logic [uvg_pkg::TOP_W-1:0]      sh;
    logic [uvg_pkg::MID_W-1:0]      sm;
    logic [uvg_pkg::LOW_W-1:0]      sl;
    logic [uvg_pkg::TIME_W-1:0]     qacc;
    logic [uvg_pkg::V_W-1:0]        v;
    logic [uvg_pkg::PROD_W-1:0]     prod;
  } mul_t;

  // Beat after the remainder of one chunk step.
  typedef struct packed {
    logic                           valid;
    logic [uvg_pkg::TIME_W-1:0]     t;
    logic [uvg_pkg::TOP_W-1:0]      sh;
    logic [uvg_pkg::MID_W-1:0]      sm;
    logic [uvg_pkg::LOW_W-1:0]      sl;
    logic [uvg_pkg::TIME_W-1:0]     qacc;
    logic [uvg_pkg::REM_W-1:0]      r;
  } rem_t;

  mul_t ms [NC];
  rem_t rs [NC];
  rem_t rs_in;
  logic adv;

  // The whole pipeline moves together; it halts only when its last beat
  // cannot enter the queue.
  assign adv  = !(rs[NC-1].valid && !out_ready);
  assign full = !adv;

  always_comb begin
    rs_in.valid = push && adv;
    rs_in.t     = time_us;
    rs_in.sh    = seed_high;
    rs_in.sm    = seed_mid;
    rs_in.sl    = seed_low;
    rs_in.qacc  = '0;
    rs_in.r     = '0;
  end

  for (genvar j = 0; j < NC; j++) begin : g_chunk
    rem_t src;
    mul_t mn;
    rem_t rn;
    logic [uvg_pkg::CHUNK_W-1:0] q;

    if (j == 0) begin : g_first
      assign src = rs_in;
    end else begin : g_next
      assign src = rs[j-1];
    end

    always_comb begin
      mn.valid = src.valid;
      mn.t     = src.t;
      mn.sh    = src.sh;
      mn.sm    = src.sm;
      mn.sl    = src.sl;
      mn.qacc  = src.qacc;
      mn.v     = {src.r, src.t[uvg_pkg::CHUNK_W*(NC-1-j) +: uvg_pkg::CHUNK_W]};
      mn.prod  = uvg_pkg::PROD_W'(mn.v) * uvg_pkg::PROD_W'(uvg_pkg::RECIP_M);
    end

    assign q = ms[j].prod[uvg_pkg::RECIP_SHIFT +: uvg_pkg::CHUNK_W];

    always_comb begin
      rn.valid = ms[j].valid;
      rn.t     = ms[j].t;
      rn.sh    = ms[j].sh;
      rn.sm    = ms[j].sm;
      rn.sl    = ms[j].sl;
      rn.qacc  = {ms[j].qacc[uvg_pkg::TIME_W-uvg_pkg::CHUNK_W-1:0], q};
      rn.r     = uvg_pkg::REM_W'(ms[j].v - uvg_pkg::V_W'(q) * uvg_pkg::V_W'(uvg_pkg::US_PER_MS));
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ms[j].valid <= 1'b0;
        rs[j].valid <= 1'b0;
      end else if (adv) begin
        ms[j] <= mn;
        rs[j] <= rn;
      end
    end
  end

  always_comb begin
    out.valid          = rs[NC-1].valid;
    out.item.ms        = rs[NC-1].qacc;
    out.item.sub       = rs[NC-1].r;
    out.item.seed_high = rs[NC-1].sh;
    out.item.seed_mid  = rs[NC-1].sm;
    out.item.seed_low  = rs[NC-1].sl;
  end

endmodule

/* rtl/uvg_back.sv */
module uvg_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  uvg_pkg::item_t   in_item,
  output logic             in_pop,
  input  logic             out_full,
  output logic             res_push,
  output uvg_pkg::result_t res
);

  logic                         started;
  logic [uvg_pkg::TIME_W-1:0]   logical_millis;
  logic [uvg_pkg::REM_W-1:0]    last_sub_micros;
  logic [uvg_pkg::CNT_W-1:0]    count;

  logic [uvg_pkg::TIME_W-1:0]   base_ms;
  logic [uvg_pkg::REM_W-1:0]    base_sub;
  logic [uvg_pkg::CNT_W-1:0]    base_cnt;
  logic [uvg_pkg::CNT_W-1:0]    seed_cnt;
  logic [uvg_pkg::TIME_W-1:0]   logical_millis_next;
  logic [uvg_pkg::REM_W-1:0]    last_sub_micros_next;
  logic [uvg_pkg::CNT_W-1:0]    count_next;
  logic                         fire;

  assign fire     = in_valid && !out_full;
  assign in_pop   = fire;
  assign res_push = fire;
  assign seed_cnt = {in_item.seed_high, in_item.seed_mid, in_item.seed_low};

  always_comb begin
    // Before the first beat the state is taken from the beat itself, which then
    // compares equal and increments the seeded counter (a new millisecond if all ones).
    base_ms  = started ? logical_millis : in_item.ms;
    base_sub = started ? last_sub_micros : in_item.sub;
    base_cnt = started ? count : seed_cnt;

    logical_millis_next  = base_ms;
    last_sub_micros_next = base_sub;
    count_next           = base_cnt;

    if (in_item.ms > base_ms) begin
      logical_millis_next  = in_item.ms;
      last_sub_micros_next = in_item.sub;
      count_next           = seed_cnt;
    end else if (in_item.ms == base_ms) begin
      if (in_item.sub > base_sub) begin
        last_sub_micros_next = in_item.sub;
        count_next           = seed_cnt;
      end else if (in_item.sub == base_sub) begin
        if (&base_cnt) begin
          logical_millis_next  = base_ms + 1'b1;
          last_sub_micros_next = '0;
          count_next           = seed_cnt;
        end else begin
          count_next = base_cnt + 1'b1;
        end
      end
    end

    res.upper = {logical_millis_next[47:0], uvg_pkg::VERSION, last_sub_micros_next,
                 count_next[uvg_pkg::CNT_W-uvg_pkg::TOP_W +: 2]};
    res.lower = {uvg_pkg::VARIANT, count_next[uvg_pkg::CNT_W-uvg_pkg::TOP_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started         <= 1'b0;
      logical_millis  <= '0;
      last_sub_micros <= '0;
      count           <= '0;
    end else if (fire) begin
      started         <= 1'b1;
      logical_millis  <= logical_millis_next;
      last_sub_micros <= last_sub_micros_next;
      count           <= count_next;
    end
  end

endmodule

/* rtl/uuid_v7_monotonic_generator.sv */
// Channel   Handshake      Fields
// request   push / full    time_us, seed_high, seed_mid, seed_low
// uuid      pop / empty    uuid_upper, uuid_lower
//
// One request is taken every cycle while full is low; a request's UUID reaches the
// result ports through the eight-stage divide-by-1000 pipeline, the queue behind it
// and the result queue.
// The counter update in the back part handles one beat per cycle while the result queue has room.
// Reset clears the generator state and empties both queues.
// With pop held low the result queue fills, then the middle queue, then full rises.
module uuid_v7_monotonic_generator #(
  parameter int unsigned MID_DEPTH = 4,
  parameter int unsigned OUT_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [63:0] time_us,
  input  logic [11:0] seed_high,
  input  logic [13:0] seed_mid,
  input  logic [47:0] seed_low,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] uuid_upper,
  output logic [63:0] uuid_lower
);

  uvg_pkg::item_beat_t front_out;
  uvg_pkg::item_t      mid_item;
  uvg_pkg::result_t    res;
  uvg_pkg::result_t    out_head;
  logic                mid_full;
  logic                mid_empty;
  logic                mid_pop;
  logic                out_full;
  logic                res_push;

  uvg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .time_us   (time_us),
    .seed_high (seed_high),
    .seed_mid  (seed_mid),
    .seed_low  (seed_low),
    .full      (full),
    .out_ready (!mid_full),
    .out       (front_out)
  );

  uvg_fifo #(
    .WIDTH ($bits(uvg_pkg::item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (front_out.valid),
    .wr_data (front_out.item),
    .full    (mid_full),
    .pop     (mid_pop),
    .rd_data (mid_item),
    .empty   (mid_empty)
  );

  uvg_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (!mid_empty),
    .in_item  (mid_item),
    .in_pop   (mid_pop),
    .out_full (out_full),
    .res_push (res_push),
    .res      (res)
  );

  uvg_fifo #(
    .WIDTH ($bits(uvg_pkg::result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_data (res),
    .full    (out_full),
    .pop     (pop),
    .rd_data (out_head),
    .empty   (empty)
  );

  assign uuid_upper = out_head.upper;
  assign uuid_lower = out_head.lower;

  // The input stalls only while the last front beat waits on a full middle queue.
  a_full_cause: assert property (@(posedge clk) disable iff (rst)
    full |-> (front_out.valid && mid_full))
    else $error("input stalled without a waiting front beat");

  // A held front beat stays put until the middle queue frees a slot.
  a_front_holds: assert property (@(posedge clk) disable iff (rst)
    (front_out.valid && mid_full) |=> front_out.valid)
    else $error("front beat dropped while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_version_variant: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (uuid_upper[15:12] == uvg_pkg::VERSION &&
                uuid_lower[63:62] == uvg_pkg::VARIANT))
    else $error("version or variant bits wrong");

endmodule
